FILE: src/fsg_pkg.sv
// ----------------------------------------------------------------------------
// fsg_pkg
// shared types and constants for the falling sand grid block
// ----------------------------------------------------------------------------
package fsg_pkg;

   localparam int GRID_COLUMNS_DEFAULT = 256;
   localparam int GRID_ROWS_DEFAULT    = 256;

   localparam int CMD_WIDTH   = 2;
   localparam int COORD_WIDTH = 8;

   localparam logic [CMD_WIDTH-1:0] CMD_PAINT   = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_ADVANCE = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_READ    = 2'd2;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]   cmd;
      logic [COORD_WIDTH-1:0] row;
      logic [COORD_WIDTH-1:0] column;
   } req_type;

   typedef struct packed {
      logic                 cell_value;
      logic [CMD_WIDTH-1:0] done_cmd;
   } rsp_type;

endpackage

FILE: src/falling_sand_grid_step.sv
// ----------------------------------------------------------------------------
// falling_sand_grid_step
// one-bit falling sand grid with paint, read and advance commands
// ----------------------------------------------------------------------------
// usage
//   req channel carries one command word: paint a grain at (row, column),
//   read the cell at (row, column), or advance the grid one generation
//   rsp channel returns exactly one word per command: cell_value (read only,
//   else 0) and done_cmd, the echo of the command
//   the grid lives in one ram, one row of GRID_COLUMNS bits per entry
// command flow
//   paint, read: fetch, modify and finish states, in that order
//   unused code: finish state only
//   advance: one row per cycle streamed through the ram with a two row
//   window, then finish; a new command is accepted only back in idle
//   the grid ram has a single read and a single write port
// reset
//   after reset the ram is swept to zero, one row a cycle;
//   req_stall is high during the sweep
// stall
//   a finished result sits in the output register; the next command is
//   accepted meanwhile and waits at its end until rsp_stall drops
// ----------------------------------------------------------------------------
module falling_sand_grid_step #(
   parameter int GRID_COLUMNS = fsg_pkg::GRID_COLUMNS_DEFAULT,
   parameter int GRID_ROWS    = fsg_pkg::GRID_ROWS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fsg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fsg_pkg::rsp_type rsp_data
);

   localparam int RW = $clog2(GRID_ROWS);
   localparam int CW = $clog2(GRID_COLUMNS);
   localparam int SW = $clog2(GRID_ROWS + 2);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_MODIFY,
      ST_ADVANCE,
      ST_FINISH
   } state_type;

   // control
   state_type state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;

   // payload
   logic [fsg_pkg::CMD_WIDTH-1:0]   cmd_ff, cmd_in;
   logic [fsg_pkg::COORD_WIDTH-1:0] row_ff, row_in;
   logic [fsg_pkg::COORD_WIDTH-1:0] col_ff, col_in;
   logic value_ff, value_in;
   logic [GRID_COLUMNS-1:0] above_ff, above_in;
   logic [GRID_COLUMNS-1:0] cur_ff, cur_in;
   fsg_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // ram side
   logic                    wr_en;
   logic [RW-1:0]           wr_addr;
   logic [GRID_COLUMNS-1:0] wr_data;
   logic                    rd_en;
   logic [RW-1:0]           rd_addr;
   logic [GRID_COLUMNS-1:0] rd_data;

   logic [GRID_COLUMNS-1:0] below_row;
   logic [GRID_COLUMNS-1:0] next_row;
   logic                    on_grid;
   logic [CW-1:0]           col_idx;
   logic                    req_take;
   logic                    slot_free;
   logic                    last_step;

   fsg_ram #(
      .WIDTH (GRID_COLUMNS),
      .DEPTH (GRID_ROWS)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // bottom row: treat the row beneath as full so grains never move
   assign last_step = (step_ff == SW'(GRID_ROWS + 1));
   assign below_row = last_step ? '1 : rd_data;

   fsg_row_update #(
      .COLUMNS (GRID_COLUMNS)
   ) u_row_update (
      .above_row (above_ff),
      .mid_row   (cur_ff),
      .below_row (below_row),
      .next_row  (next_row)
   );

   assign on_grid   = (32'(row_ff) < GRID_ROWS) && (32'(col_ff) < GRID_COLUMNS);
   assign col_idx   = CW'(col_ff);
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   // output register can take a word this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd_in       = cmd_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      value_in     = value_ff;
      above_in     = above_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = RW'(step_ff);
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = RW'(row_ff);

      case (state_ff)
         ST_CLEAR: begin
            // zero one row a cycle
            wr_en   = 1'b1;
            wr_addr = RW'(step_ff);
            wr_data = '0;
            if (step_ff == SW'(GRID_ROWS - 1)) begin
               step_in  = '0;
               state_in = ST_IDLE;
            end else begin
               step_in = step_ff + SW'(1);
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               cmd_in   = req_data.cmd;
               row_in   = req_data.row;
               col_in   = req_data.column;
               value_in = 1'b0;
               step_in  = '0;
               above_in = '0;
               cur_in   = '0;
               case (req_data.cmd)
                  fsg_pkg::CMD_PAINT:   state_in = ST_FETCH;
                  fsg_pkg::CMD_READ:    state_in = ST_FETCH;
                  fsg_pkg::CMD_ADVANCE: state_in = ST_ADVANCE;
                  default:              state_in = ST_FINISH;
               endcase
            end
         end
         ST_FETCH: begin
            rd_en    = 1'b1;
            rd_addr  = RW'(row_ff);
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            // row word is on rd_data now
            if (cmd_ff == fsg_pkg::CMD_READ) begin
               value_in = on_grid && rd_data[col_idx];
            end else begin
               wr_en    = on_grid;
               wr_addr  = RW'(row_ff);
               wr_data  = rd_data | (GRID_COLUMNS'(1) << col_idx);
               value_in = 1'b0;
            end
            state_in = ST_FINISH;
         end
         ST_ADVANCE: begin
            // read row step, data of row step-1 arrives, write row step-2
            if (step_ff < SW'(GRID_ROWS)) begin
               rd_en   = 1'b1;
               rd_addr = RW'(step_ff);
            end
            if (step_ff >= SW'(1) && !last_step) begin
               above_in = cur_ff;
               cur_in   = rd_data;
            end
            if (step_ff >= SW'(2)) begin
               wr_en   = 1'b1;
               wr_addr = RW'(step_ff - SW'(2));
               wr_data = next_row;
            end
            if (last_step) begin
               step_in  = '0;
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + SW'(1);
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.cell_value = value_ff;
               rsp_data_in.done_cmd   = cmd_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      value_ff    <= value_in;
      above_ff    <= above_in;
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: src/fsg_ram.sv
// ----------------------------------------------------------------------------
// fsg_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module fsg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/fsg_row_update.sv
// ----------------------------------------------------------------------------
// fsg_row_update
// next generation of one grid row from the old rows above, at and below it
// ----------------------------------------------------------------------------
module fsg_row_update #(
   parameter int COLUMNS = fsg_pkg::GRID_COLUMNS_DEFAULT
) (
   input  logic [COLUMNS-1:0] above_row,
   input  logic [COLUMNS-1:0] mid_row,
   input  logic [COLUMNS-1:0] below_row,
   output logic [COLUMNS-1:0] next_row
);

   // two pad cells each side: off-grid counts as empty above, blocked elsewhere
   logic [COLUMNS+3:0] above_pad;
   logic [COLUMNS+3:0] mid_pad;
   logic [COLUMNS+3:0] below_pad;

   assign above_pad = {2'b00, above_row, 2'b00};
   assign mid_pad   = {2'b11, mid_row, 2'b11};
   assign below_pad = {2'b11, below_row, 2'b11};

   always_comb begin
      for (int c = 0; c < COLUMNS; c++) begin
         next_row[c] =
            // grain stays: below and both diagonals blocked
            (mid_pad[c+2] & below_pad[c+2] & below_pad[c+1] & below_pad[c+3]) |
            // falls straight in from above
            (above_pad[c+2] & ~mid_pad[c+2]) |
            // slides down-right from the upper left, its down-left blocked
            (above_pad[c+1] & mid_pad[c+1] & ~mid_pad[c+2] & mid_pad[c]) |
            // slides down-left from the upper right
            (above_pad[c+3] & mid_pad[c+3] & ~mid_pad[c+2]);
      end
   end

endmodule

FILE: src/fsg_checker.sv
// ----------------------------------------------------------------------------
// fsg_checker
// port level checks for the falling sand grid block
// ----------------------------------------------------------------------------
module fsg_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input fsg_pkg::rsp_type rsp_data
);

   // words accepted but not yet delivered
   logic [1:0] pending_ff;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (req_take && !rsp_take) begin
         pending_ff <= pending_ff + 2'd1;
      end else if (rsp_take && !req_take) begin
         pending_ff <= pending_ff - 2'd1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   a_value_only_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.done_cmd != fsg_pkg::CMD_READ) |-> !rsp_data.cell_value)
      else $error("cell value set on a non-read result");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 2'd0))
      else $error("result word without an accepted command");

   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("command accepted during the clearing sweep");

endmodule

bind falling_sand_grid_step fsg_checker u_fsg_checker (.*);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the falling sand grid: short directed table, then
// random paint / advance / read bursts in small grid windows, each result
// compared field by field with a typed-in word or a behavioral sand model
// ----------------------------------------------------------------------------
module testbench;

   localparam int GRID_ROWS    = fsg_pkg::GRID_ROWS_DEFAULT;
   localparam int GRID_COLUMNS = fsg_pkg::GRID_COLUMNS_DEFAULT;

   // code 3 is not decoded by the block, it only echoes back
   localparam logic [fsg_pkg::CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;

   localparam int RESET_CYCLES   = 8;
   localparam int RANDOM_WORDS   = 75;
   // words per idling phase, the phases rotate through four modes
   localparam int PHASE_WORDS    = 25;
   // long receiver hold-off, started at one word of the receiver stall phase;
   // outlasts two advances so the block fills up whatever is in flight
   localparam int PRESSURE_WORD  = 60;
   localparam int HOLD_CYCLES    = 3 * GRID_ROWS;
   // long enough to cover a whole advance
   localparam int DRAIN_CYCLES   = GRID_ROWS + 16;
   // covers the clearing sweep after reset and an advance under stalls
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DIRECTED_COUNT = 25;

   // one stimulus word; fixed marks rows whose result is typed in directly
   typedef struct packed {
      fsg_pkg::req_type word;
      logic             fixed;
      fsg_pkg::rsp_type result;
   } stim_row_type;

   // directed part: fixed results only where they are obvious, the rest
   // goes through the sand model
   localparam stim_row_type DIRECTED_TABLE [DIRECTED_COUNT] = '{
      // grid is empty after reset
      '{'{fsg_pkg::CMD_READ,    8'd0,   8'd0},   1'b1, '{1'b0, fsg_pkg::CMD_READ}},
      '{'{CMD_UNUSED,           8'd255, 8'd255}, 1'b1, '{1'b0, CMD_UNUSED}},
      '{'{fsg_pkg::CMD_ADVANCE, 8'd0,   8'd0},   1'b1, '{1'b0, fsg_pkg::CMD_ADVANCE}},
      // paint top-left corner, then paint it again on a full cell
      '{'{fsg_pkg::CMD_PAINT,   8'd0,   8'd0},   1'b1, '{1'b0, fsg_pkg::CMD_PAINT}},
      '{'{fsg_pkg::CMD_READ,    8'd0,   8'd0},   1'b1, '{1'b1, fsg_pkg::CMD_READ}},
      '{'{fsg_pkg::CMD_PAINT,   8'd0,   8'd0},   1'b1, '{1'b0, fsg_pkg::CMD_PAINT}},
      '{'{fsg_pkg::CMD_READ,    8'd0,   8'd0},   1'b1, '{1'b1, fsg_pkg::CMD_READ}},
      // bottom corners, with grains above that can only slide inward
      '{'{fsg_pkg::CMD_PAINT,   8'd255, 8'd255}, 1'b1, '{1'b0, fsg_pkg::CMD_PAINT}},
      '{'{fsg_pkg::CMD_PAINT,   8'd254, 8'd255}, 1'b1, '{1'b0, fsg_pkg::CMD_PAINT}},
      '{'{fsg_pkg::CMD_PAINT,   8'd254, 8'd0},   1'b1, '{1'b0, fsg_pkg::CMD_PAINT}},
      '{'{fsg_pkg::CMD_PAINT,   8'd255, 8'd0},   1'b1, '{1'b0, fsg_pkg::CMD_PAINT}},
      // one grain slides right, its neighbor slides left, both into (11,101)
      '{'{fsg_pkg::CMD_PAINT,   8'd10,  8'd100}, 1'b1, '{1'b0, fsg_pkg::CMD_PAINT}},
      '{'{fsg_pkg::CMD_PAINT,   8'd11,  8'd100}, 1'b1, '{1'b0, fsg_pkg::CMD_PAINT}},
      '{'{fsg_pkg::CMD_PAINT,   8'd11,  8'd99},  1'b1, '{1'b0, fsg_pkg::CMD_PAINT}},
      '{'{fsg_pkg::CMD_PAINT,   8'd10,  8'd102}, 1'b1, '{1'b0, fsg_pkg::CMD_PAINT}},
      '{'{fsg_pkg::CMD_PAINT,   8'd11,  8'd102}, 1'b1, '{1'b0, fsg_pkg::CMD_PAINT}},
      '{'{fsg_pkg::CMD_PAINT,   8'd11,  8'd103}, 1'b1, '{1'b0, fsg_pkg::CMD_PAINT}},
      // blocked below with both diagonals free, left wins
      '{'{fsg_pkg::CMD_PAINT,   8'd20,  8'd50},  1'b1, '{1'b0, fsg_pkg::CMD_PAINT}},
      '{'{fsg_pkg::CMD_PAINT,   8'd21,  8'd50},  1'b1, '{1'b0, fsg_pkg::CMD_PAINT}},
      '{'{fsg_pkg::CMD_ADVANCE, 8'd0,   8'd0},   1'b1, '{1'b0, fsg_pkg::CMD_ADVANCE}},
      '{'{fsg_pkg::CMD_READ,    8'd11,  8'd101}, 1'b0, '0},
      '{'{fsg_pkg::CMD_READ,    8'd255, 8'd254}, 1'b0, '0},
      '{'{fsg_pkg::CMD_READ,    8'd255, 8'd1},   1'b0, '0},
      '{'{fsg_pkg::CMD_READ,    8'd21,  8'd49},  1'b0, '0},
      '{'{fsg_pkg::CMD_READ,    8'd1,   8'd0},   1'b0, '0}
   };

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   fsg_pkg::req_type req_data    = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   fsg_pkg::rsp_type rsp_data;

   // travels with the word on the bench side only
   logic             word_fixed        = 1'b0;
   fsg_pkg::rsp_type word_fixed_result = '0;

   // sand model state, one packed row per grid row
   bit [GRID_COLUMNS-1:0] sand_rows [GRID_ROWS];

   stim_row_type     stimulus [$];
   fsg_pkg::rsp_type pending_results [$];
   int               mismatch_count = 0;
   int               quiet_cycles   = 0;
   int               idle_pct       = 0;
   int               stall_pct      = 0;
   bit               hold_request   = 1'b0;

   always #2 clock = ~clock;

   falling_sand_grid_step i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // one generation: every decision looks at the old grid only, writes go
   // to a copy, so grains landing in the same cell simply merge
   function automatic void drop_grains();
      bit [GRID_COLUMNS-1:0] settled [GRID_ROWS];
      bit [GRID_COLUMNS-1:0] below;
      bit                    right_free;
      bit                    left_free;
      settled = sand_rows;
      // bottom row never moves, so stop one row short
      for (int r = 0; r + 1 < GRID_ROWS; r++) begin
         below = sand_rows[r + 1];
         for (int c = 0; c < GRID_COLUMNS; c++) begin
            if (sand_rows[r][c]) begin
               // a column off the grid counts as blocked
               right_free = (c + 1 < GRID_COLUMNS) && !below[c + 1];
               left_free  = (c > 0) && !below[c - 1];
               if (!below[c]) begin
                  settled[r][c]     = 1'b0;
                  settled[r + 1][c] = 1'b1;
               end else if (right_free && !left_free) begin
                  settled[r][c]         = 1'b0;
                  settled[r + 1][c + 1] = 1'b1;
               end else if (left_free) begin
                  settled[r][c]         = 1'b0;
                  settled[r + 1][c - 1] = 1'b1;
               end
            end
         end
      end
      sand_rows = settled;
   endfunction

   // applies one command to the sand model and returns its result word
   function automatic fsg_pkg::rsp_type apply_command(fsg_pkg::req_type w);
      fsg_pkg::rsp_type r;
      bit               on_grid;
      r          = '0;
      r.done_cmd = w.cmd;
      on_grid    = (int'(w.row) < GRID_ROWS) && (int'(w.column) < GRID_COLUMNS);
      case (w.cmd)
         fsg_pkg::CMD_PAINT:   if (on_grid) sand_rows[w.row][w.column] = 1'b1;
         fsg_pkg::CMD_ADVANCE: drop_grains();
         fsg_pkg::CMD_READ:    if (on_grid) r.cell_value = sand_rows[w.row][w.column];
         default:              ;
      endcase
      return r;
   endfunction

   function automatic logic [fsg_pkg::COORD_WIDTH-1:0] clip_coord(int v);
      if (v < 0) return '0;
      if (v > 255) return '1;
      return v[fsg_pkg::COORD_WIDTH-1:0];
   endfunction

   // window corners lean toward the grid edges
   function automatic int pick_corner();
      case ($urandom_range(3))
         0:       return 0;
         1:       return 252;
         default: return $urandom_range(252);
      endcase
   endfunction

   task automatic add_word(logic [fsg_pkg::CMD_WIDTH-1:0] cmd, int r, int c);
      stim_row_type s;
      s             = '0;
      s.word.cmd    = cmd;
      s.word.row    = clip_coord(r);
      s.word.column = clip_coord(c);
      stimulus.push_back(s);
   endtask

   // random part: mostly bursts that paint a few grains in a 4x4 window,
   // advance once or twice and read around where they should have landed;
   // the rest is single words with any code and any address
   task automatic build_random_words();
      int        base_r;
      int        base_c;
      int        steps;
      bit [31:0] pick;
      while (stimulus.size() < DIRECTED_COUNT + RANDOM_WORDS) begin
         if ($urandom_range(9) < 7) begin
            base_r = pick_corner();
            base_c = pick_corner();
            repeat ($urandom_range(3, 8))
               add_word(fsg_pkg::CMD_PAINT, base_r + $urandom_range(3),
                        base_c + $urandom_range(3));
            steps = $urandom_range(1, 2);
            repeat (steps)
               add_word(fsg_pkg::CMD_ADVANCE, $urandom_range(255), $urandom_range(255));
            repeat ($urandom_range(2, 5))
               add_word(fsg_pkg::CMD_READ, base_r + $urandom_range(3 + steps),
                        base_c + $urandom_range(5) - 1);
         end else begin
            pick = $urandom_range(3);
            add_word(pick[fsg_pkg::CMD_WIDTH-1:0], $urandom_range(255), $urandom_range(255));
         end
      end
   endtask

   // offers one word, with random idle cycles first, and returns at the
   // edge that accepted it; valid stays high for a back-to-back word
   task automatic send_word(stim_row_type s);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data          <= s.word;
      word_fixed        <= s.fixed;
      word_fixed_result <= s.result;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // receiver side: random stalls per phase, or one long hold-off on request
   // so the block fills up and pushes back on its input
   initial begin : drive_rsp_stall
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
            @(posedge clock);
         end
      end
   end

   // accepted command words feed the model, accepted result words are
   // checked against the oldest expectation
   always @(posedge clock) begin : check_words
      fsg_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            want = apply_command(req_data);
            if (word_fixed) want = word_fixed_result;
            pending_results.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result word with no expected word waiting");
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.cell_value !== want.cell_value) begin
                  $error("cell_value expected %0d got %0d", want.cell_value,
                         rsp_data.cell_value);
                  mismatch_count++;
               end
               if (rsp_data.done_cmd !== want.done_cmd) begin
                  $error("done_cmd expected %0d got %0d", want.done_cmd, rsp_data.done_cmd);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // ends a hung run: counts cycles with no word accepted on either side
   always @(posedge clock) begin : watchdog
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   initial begin : run_words
      int mode;
      foreach (DIRECTED_TABLE[i]) stimulus.push_back(DIRECTED_TABLE[i]);
      build_random_words();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // phases: no idling, sender idle, receiver stalling, both
      foreach (stimulus[i]) begin
         mode      = (i / PHASE_WORDS) % 4;
         idle_pct  = (mode == 1) ? 56 : (mode == 3) ? 28 : 0;
         stall_pct = (mode == 2) ? 56 : (mode == 3) ? 28 : 0;
         if (i == PRESSURE_WORD) hold_request = 1'b1;
         send_word(stimulus[i]);
      end
      req_valid <= 1'b0;

      // let the last results come out, then watch for stray words
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
